[rtl/shortest_remaining_time_scheduler_macros.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_MACROS_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SRTS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("scheduler assertion failed");

// next-cycle implication
`define SRTS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("scheduler assertion failed");

`else

`define SRTS_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define SRTS_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

[rtl/srts_pkg.sv]
package srts_pkg;

	localparam int MAX_PROCS_DEF = 16;
	localparam int DATA_W        = 16;
	localparam int SLOT_IN_W     = 4;
	localparam int PC_W          = 5;
	localparam int TIME_W        = 32;

	localparam logic [PC_W-1:0] PC_RESET = 5'd16;
	localparam logic [PC_W-1:0] FIN_TOP  = 5'd31;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// one slot table entry
	typedef struct packed {
		logic [DATA_W-1:0] arrival;
		logic [DATA_W-1:0] remaining;
		logic [DATA_W-1:0] burst;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/shortest_remaining_time_scheduler.sv]
// Preemptive shortest-remaining-time-first scheduler. A load word (kind 0)
// writes one slot's arrival tick and burst and returns no result; loads
// to a slot at or above MAX_PROCS are dropped. A tick word (kind 1)
// scans the slots in use one per cycle through the slot RAM's single read
// port, picks the arrived slot with the least remaining work (lowest slot on
// ties), serves it, and returns one result word. A tick holds the input
// through the scan of the n slots in use (n being process_count clamped to
// MAX_PROCS), the turnaround, wait, running-sum and output steps on a
// 33-bit datapath, and while the output waits on a stalled consumer. Loads
// are taken while a result still sits in the output register. Times and sums
// saturate at all ones, finished count at 31. The user must write process_count
// through cfg_we/cfg_wdata only while the block is idle; the block does not
// enforce it. It resets to 16; zero leaves no slot in use (all_done reads 1).
`include "shortest_remaining_time_scheduler_macros.svh"

module shortest_remaining_time_scheduler #(
	parameter int MAX_PROCS = srts_pkg::MAX_PROCS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// config
	input  logic                           cfg_we,
	input  logic [srts_pkg::PC_W-1:0]      cfg_wdata,
	// input words
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           kind,
	input  logic [srts_pkg::SLOT_IN_W-1:0] slot,
	input  logic [srts_pkg::DATA_W-1:0]    arrival,
	input  logic [srts_pkg::DATA_W-1:0]    burst,
	// result words
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [srts_pkg::SLOT_IN_W-1:0] running_slot,
	output logic                           idle,
	output logic                           finished,
	output logic [srts_pkg::TIME_W-1:0]    wait_of_finished,
	output logic [srts_pkg::TIME_W-1:0]    turnaround_of_finished,
	output logic [srts_pkg::TIME_W-1:0]    total_wait,
	output logic [srts_pkg::TIME_W-1:0]    total_turnaround,
	output logic                           all_done
);

	import srts_pkg::*;

	localparam int SLOT_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W  = $clog2(MAX_PROCS + 1);
	localparam int CMP_W  = (CNT_W > PC_W) ? CNT_W : PC_W;
	localparam int LD_W   = (CNT_W > SLOT_IN_W) ? CNT_W : SLOT_IN_W;
	localparam int PAD_W  = TIME_W - DATA_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_TURN,
		S_WAIT,
		S_SUM,
		S_PUT
	} state_t;

	state_t state_q;

	logic [PC_W-1:0]      process_count_q;
	logic [MAX_PROCS-1:0] valid_q;
	logic [TIME_W-1:0]    tick_q;
	logic [PC_W-1:0]      fin_cnt_q;
	logic [TIME_W-1:0]    wait_sum_q;
	logic [TIME_W-1:0]    turn_sum_q;

	// scan
	logic [CNT_W-1:0]  iss_q;
	logic              pend_s1;
	logic [SLOT_W-1:0] rd_idx_s1;
	logic              found_q;
	logic [SLOT_W-1:0] best_q;
	logic [DATA_W-1:0] best_arr_q;
	logic [DATA_W-1:0] best_rem_q;
	logic [DATA_W-1:0] best_bur_q;

	// finish math
	logic              fin_q;
	logic [TIME_W:0]   turn_q;
	logic [TIME_W-1:0] wait_q;
	logic [TIME_W-1:0] turn_sat_q;

	// output register
	logic                 out_valid_q;
	logic [SLOT_IN_W-1:0] running_slot_q;
	logic                 idle_q;
	logic                 finished_q;
	logic [TIME_W-1:0]    wait_out_q;
	logic [TIME_W-1:0]    turn_out_q;
	logic [TIME_W-1:0]    total_wait_q;
	logic [TIME_W-1:0]    total_turn_q;
	logic                 all_done_q;

	logic [CNT_W-1:0]   n_eff;
	logic               load_ok;
	logic               issue;
	logic               ram_we;
	logic [SLOT_W-1:0]  ram_waddr;
	entry_t             ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd;
	logic               elig;
	logic               smaller;
	logic [TIME_W:0]    bur_ext;
	logic [TIME_W:0]    wait_diff;
	logic [TIME_W:0]    wait_full;
	logic [TIME_W-1:0]  wait_sat;
	logic [TIME_W:0]    wsum_full;
	logic [TIME_W:0]    tsum_full;

	// slots in use, clamped to the table size
	always_comb begin
		if (CMP_W'(process_count_q) > CMP_W'(MAX_PROCS)) begin
			n_eff = CNT_W'(MAX_PROCS);
		end else begin
			n_eff = CNT_W'(process_count_q);
		end
	end

	assign load_ok  = LD_W'(slot) < LD_W'(MAX_PROCS);
	assign in_ready = (state_q == S_IDLE);
	assign issue    = (state_q == S_SCAN) && (iss_q < n_eff);

	// single write port: loads in idle, the decrement after a scan
	always_comb begin
		if (state_q == S_IDLE) begin
			ram_we              = in_valid && (kind == KIND_LOAD) && load_ok;
			ram_waddr           = SLOT_W'(slot);
			ram_wdata.arrival   = arrival;
			ram_wdata.remaining = burst;
			ram_wdata.burst     = burst;
		end else begin
			ram_we              = (state_q == S_TURN) && found_q;
			ram_waddr           = best_q;
			ram_wdata.arrival   = best_arr_q;
			ram_wdata.remaining = best_rem_q - DATA_W'(1);
			ram_wdata.burst     = best_bur_q;
		end
	end

	srts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_PROCS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (iss_q[SLOT_W-1:0]),
		.rdata (ram_rdata)
	);

	assign rd = entry_t'(ram_rdata);

	// never-loaded slots read as zero work through the valid bits
	assign elig    = valid_q[rd_idx_s1] && ({{PAD_W{1'b0}}, rd.arrival} <= tick_q)
		&& (rd.remaining != '0);
	assign smaller = rd.remaining < best_rem_q;

	// wait = turnaround - burst, floored at zero, from the unsaturated turnaround
	assign bur_ext   = {{(PAD_W + 1){1'b0}}, best_bur_q};
	assign wait_diff = turn_q - bur_ext;
	assign wait_full = (turn_q >= bur_ext) ? wait_diff : '0;
	assign wait_sat  = wait_full[TIME_W] ? '1 : wait_full[TIME_W-1:0];

	assign wsum_full = {1'b0, wait_sum_q} + {1'b0, wait_q};
	assign tsum_full = {1'b0, turn_sum_q} + {1'b0, turn_sat_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			process_count_q <= PC_RESET;
			valid_q         <= '0;
			tick_q          <= '0;
			fin_cnt_q       <= '0;
			wait_sum_q      <= '0;
			turn_sum_q      <= '0;
			iss_q           <= '0;
			pend_s1         <= 1'b0;
			rd_idx_s1       <= '0;
			found_q         <= 1'b0;
			best_q          <= '0;
			best_arr_q      <= '0;
			best_rem_q      <= '0;
			best_bur_q      <= '0;
			fin_q           <= 1'b0;
			turn_q          <= '0;
			wait_q          <= '0;
			turn_sat_q      <= '0;
			out_valid_q     <= 1'b0;
			running_slot_q  <= '0;
			idle_q          <= 1'b0;
			finished_q      <= 1'b0;
			wait_out_q      <= '0;
			turn_out_q      <= '0;
			total_wait_q    <= '0;
			total_turn_q    <= '0;
			all_done_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				process_count_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// read pipeline and running minimum
			pend_s1   <= issue;
			rd_idx_s1 <= iss_q[SLOT_W-1:0];
			if (pend_s1 && elig && (!found_q || smaller)) begin
				found_q    <= 1'b1;
				best_q     <= rd_idx_s1;
				best_arr_q <= rd.arrival;
				best_rem_q <= rd.remaining;
				best_bur_q <= rd.burst;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (kind == KIND_TICK) begin
							iss_q   <= '0;
							found_q <= 1'b0;
							state_q <= S_SCAN;
						end else if (load_ok) begin
							valid_q[SLOT_W'(slot)] <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					// last compare lands on the same edge we leave
					if (issue) begin
						iss_q <= iss_q + CNT_W'(1);
					end else begin
						state_q <= S_TURN;
					end
				end
				S_TURN: begin
					fin_q   <= found_q && (best_rem_q == DATA_W'(1));
					turn_q  <= {1'b0, tick_q} - {{(PAD_W + 1){1'b0}}, best_arr_q}
						+ (TIME_W + 1)'(1);
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (fin_q) begin
						wait_q     <= wait_sat;
						turn_sat_q <= turn_q[TIME_W] ? '1 : turn_q[TIME_W-1:0];
					end else begin
						wait_q     <= '0;
						turn_sat_q <= '0;
					end
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (fin_q) begin
						wait_sum_q <= wsum_full[TIME_W] ? '1 : wsum_full[TIME_W-1:0];
						turn_sum_q <= tsum_full[TIME_W] ? '1 : tsum_full[TIME_W-1:0];
						if (fin_cnt_q != FIN_TOP) begin
							fin_cnt_q <= fin_cnt_q + PC_W'(1);
						end
					end
					if (tick_q != '1) begin
						tick_q <= tick_q + TIME_W'(1);
					end
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						running_slot_q <= found_q ? SLOT_IN_W'(best_q) : '0;
						idle_q         <= !found_q;
						finished_q     <= fin_q;
						wait_out_q     <= wait_q;
						turn_out_q     <= turn_sat_q;
						total_wait_q   <= wait_sum_q;
						total_turn_q   <= turn_sum_q;
						all_done_q     <= CMP_W'(fin_cnt_q) >= CMP_W'(n_eff);
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid              = out_valid_q;
	assign running_slot           = running_slot_q;
	assign idle                   = idle_q;
	assign finished               = finished_q;
	assign wait_of_finished       = wait_out_q;
	assign turnaround_of_finished = turn_out_q;
	assign total_wait             = total_wait_q;
	assign total_turnaround       = total_turn_q;
	assign all_done               = all_done_q;

	// an idle tick never finishes a slot
	`SRTS_ASSERT_NOW(a_idle_not_fin, clk, arst_n, out_valid && finished, !idle)
	// wait is turnaround minus burst, so never larger
	`SRTS_ASSERT_NOW(a_wait_le_turn, clk, arst_n, out_valid && finished, wait_of_finished <= turnaround_of_finished)
	// the saturating totals keep the same ordering
	`SRTS_ASSERT_NOW(a_sum_order, clk, arst_n, out_valid, total_wait <= total_turnaround)
	// a taken tick occupies the sequencer
	`SRTS_ASSERT_NEXT(a_tick_busy, clk, arst_n, in_valid && in_ready && kind, !in_ready)

endmodule

[rtl/srts_ram.sv]
module srts_ram #(
	parameter int WIDTH = srts_pkg::ENTRY_W,
	parameter int DEPTH = srts_pkg::MAX_PROCS_DEF
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
